// File: rtl/pota_pkg.sv
// pota_pkg: shared constants and codes for the page owner table allocator
// depends on nothing; used by page_owner_table_allocator_top
package pota_pkg;

   localparam int PAGES_DEFAULT      = 64;
   localparam int PAGE_BYTES_DEFAULT = 4096;
   localparam int OWNER_BITS_DEFAULT = 8;

   localparam logic [31:0] BASE_ADDRESS_RESET = 32'h0080_0000;

   localparam int CMD_W    = 2;
   localparam int OWNER_W  = 8;
   localparam int COUNT_W  = 7;
   localparam int STATUS_W = 2;
   localparam int INDEX_W  = 6;
   localparam int ADDR_W   = 32;
   localparam int REQ_W    = 24;
   localparam int RSP_W    = 48;

   typedef enum logic [CMD_W-1:0] {
      CMD_ALLOC_ONE = 2'd0,
      CMD_ALLOC_RUN = 2'd1,
      CMD_FREE      = 2'd2,
      CMD_RESIZE    = 2'd3
   } cmd_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK        = 2'd0,
      STATUS_NO_ROOM   = 2'd1,
      STATUS_BAD_COUNT = 2'd2
   } status_type;

endpackage

// File: rtl/pota_ram.sv
// pota_ram: single-port-write, single-port-read owner table memory
// read data registered; no package dependency
module pota_ram #(
   parameter int DEPTH = 64,
   parameter int WIDTH = 9
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/page_owner_table_allocator_top.sv
// page_owner_table_allocator_top: first-fit page allocator over an owner table
// depends on pota_pkg and pota_ram
//
// One command word is taken at a time. After reset a clearing pass over every entry
// frees the table; req_tready stays low during it. Free-owner scans the whole table,
// alloc one/run scans it and then claims page_count entries, and resize also releases
// up to old_count entries of the old run; every scan goes through the single read
// port of the owner table, one entry per cycle. A finished result waits in the
// output register while the next command is taken.
module page_owner_table_allocator_top #(
   parameter int PAGES      = pota_pkg::PAGES_DEFAULT,
   parameter int PAGE_BYTES = pota_pkg::PAGE_BYTES_DEFAULT,
   parameter int OWNER_BITS = pota_pkg::OWNER_BITS_DEFAULT
) (
   input  logic                        clock,
   input  logic                        reset,
   // cmd[1:0], owner_id[9:2], page_count[16:10], old_count[23:17]
   input  logic [pota_pkg::REQ_W-1:0]  req_tdata,
   input  logic                        req_tvalid,
   output logic                        req_tready,
   // status[1:0], page_index[7:2], start_address[39:8], pages_freed[46:40], zero[47]
   output logic [pota_pkg::RSP_W-1:0]  rsp_tdata,
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   input  logic [pota_pkg::ADDR_W-1:0] csr_data,
   input  logic                        csr_valid,
   output logic                        csr_ready
);

   localparam int AW  = (PAGES > 1) ? $clog2(PAGES) : 1;
   localparam int PW  = AW + 1;
   localparam int SW  = ((AW > pota_pkg::COUNT_W) ? AW : pota_pkg::COUNT_W) + 1;
   localparam int EW  = OWNER_BITS + 1;
   localparam int CW  = pota_pkg::COUNT_W;
   localparam logic [PW-1:0] PAGES_P = PW'(PAGES);
   localparam logic [SW-1:0] PAGES_S = SW'(PAGES);
   localparam logic [31:0]   PAGE_BYTES_W = 32'(PAGE_BYTES);

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_FREE_SCAN,
      ST_RUN_SCAN,
      ST_CLAIM,
      ST_REL_SCAN,
      ST_DONE
   } state_type;

   state_type                  state_ff, state_in;
   logic [PW-1:0]              ptr_ff, ptr_in;
   logic [PW-1:0]              end_ff, end_in;
   logic                       pend_ff, pend_in;
   logic [AW-1:0]              pend_idx_ff, pend_idx_in;
   pota_pkg::cmd_type          cmd_ff, cmd_in;
   logic [OWNER_BITS-1:0]      who_ff, who_in;
   logic [CW-1:0]              len_ff, len_in;
   logic [CW-1:0]              old_ff, old_in;
   logic [CW-1:0]              run_ff, run_in;
   logic                       found_ff, found_in;
   logic [AW-1:0]              start_ff, start_in;
   logic                       have_old_ff, have_old_in;
   logic [AW-1:0]              mark_ff, mark_in;
   logic [CW-1:0]              freed_ff, freed_in;
   logic [CW-1:0]              left_ff, left_in;
   logic [31:0]                prod_ff, prod_in;
   logic [31:0]                base_ff, base_in;
   pota_pkg::status_type       status_ff, status_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic [pota_pkg::RSP_W-1:0] rsp_data_ff, rsp_data_in;

   logic          wr_en;
   logic [AW-1:0] wr_addr;
   logic [EW-1:0] wr_data;
   logic [EW-1:0] rd_data;

   logic                     issue;
   logic                     entry_busy;
   logic                     entry_mine;
   logic                     claimed;
   logic [SW-1:0]            rel_sum;
   pota_pkg::cmd_type        req_cmd;
   logic [OWNER_BITS-1:0]    req_who;
   logic [CW-1:0]            req_len;
   logic [31:0]              addr_out;

   pota_ram #(
      .DEPTH (PAGES),
      .WIDTH (EW)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (ptr_ff[AW-1:0]),
      .rd_data (rd_data)
   );

   assign req_tready = (state_ff == ST_IDLE);
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   assign req_cmd = pota_pkg::cmd_type'(req_tdata[1:0]);
   assign req_who = OWNER_BITS'(req_tdata[9:2]);
   assign req_len = (req_cmd == pota_pkg::CMD_ALLOC_ONE) ? CW'(1) : req_tdata[16:10];

   assign issue      = (ptr_ff != end_ff);
   assign entry_busy = rd_data[EW-1];
   assign entry_mine = entry_busy && (rd_data[OWNER_BITS-1:0] == who_ff);
   assign rel_sum    = SW'(mark_ff) + SW'(old_ff);
   assign claimed    = (status_ff == pota_pkg::STATUS_OK) && (cmd_ff != pota_pkg::CMD_FREE);
   assign addr_out   = base_ff + prod_ff;

   always_comb begin
      state_in     = state_ff;
      ptr_in       = ptr_ff;
      end_in       = end_ff;
      pend_in      = pend_ff;
      pend_idx_in  = pend_idx_ff;
      cmd_in       = cmd_ff;
      who_in       = who_ff;
      len_in       = len_ff;
      old_in       = old_ff;
      run_in       = run_ff;
      found_in     = found_ff;
      start_in     = start_ff;
      have_old_in  = have_old_ff;
      mark_in      = mark_ff;
      freed_in     = freed_ff;
      left_in      = left_ff;
      prod_in      = prod_ff;
      base_in      = base_ff;
      status_in    = status_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      wr_en        = 1'b0;
      wr_addr      = pend_idx_ff;
      wr_data      = '0;

      if (csr_valid) begin
         base_in = csr_data;
      end

      if (state_ff == ST_FREE_SCAN || state_ff == ST_RUN_SCAN || state_ff == ST_REL_SCAN) begin
         pend_in     = issue;
         pend_idx_in = ptr_ff[AW-1:0];
         if (issue) begin
            ptr_in = ptr_ff + PW'(1);
         end
      end

      unique case (state_ff)
         ST_CLEAR: begin
            wr_en   = 1'b1;
            wr_addr = ptr_ff[AW-1:0];
            ptr_in  = ptr_ff + PW'(1);
            if (ptr_ff == PAGES_P - PW'(1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd_in      = req_cmd;
               who_in      = req_who;
               len_in      = req_len;
               old_in      = req_tdata[23:17];
               run_in      = '0;
               found_in    = 1'b0;
               have_old_in = 1'b0;
               freed_in    = '0;
               status_in   = pota_pkg::STATUS_OK;
               ptr_in      = '0;
               end_in      = PAGES_P;
               pend_in     = 1'b0;
               if (req_cmd == pota_pkg::CMD_FREE) begin
                  state_in = ST_FREE_SCAN;
               end else if (req_len == '0 || int'(req_len) > PAGES) begin
                  status_in = pota_pkg::STATUS_BAD_COUNT;
                  state_in  = ST_DONE;
               end else begin
                  state_in = ST_RUN_SCAN;
               end
            end
         end
         ST_FREE_SCAN: begin
            if (pend_ff && entry_mine) begin
               wr_en    = 1'b1;
               freed_in = freed_ff + CW'(1);
            end
            if (!issue && !pend_ff) begin
               state_in = ST_DONE;
            end
         end
         ST_RUN_SCAN: begin
            if (pend_ff) begin
               if (!found_ff) begin
                  if (!entry_busy) begin
                     run_in = run_ff + CW'(1);
                     if (run_ff + CW'(1) == len_ff) begin
                        found_in = 1'b1;
                        start_in = pend_idx_ff - AW'(len_ff - CW'(1));
                     end
                  end else begin
                     run_in = '0;
                  end
               end
               if (cmd_ff == pota_pkg::CMD_RESIZE && !have_old_ff && entry_mine) begin
                  have_old_in = 1'b1;
                  mark_in     = pend_idx_ff;
               end
            end
            if (!issue && !pend_ff) begin
               if (found_ff) begin
                  ptr_in   = PW'(start_ff);
                  left_in  = len_ff;
                  state_in = ST_CLAIM;
               end else begin
                  status_in = pota_pkg::STATUS_NO_ROOM;
                  state_in  = ST_DONE;
               end
            end
         end
         ST_CLAIM: begin
            wr_en   = 1'b1;
            wr_addr = ptr_ff[AW-1:0];
            wr_data = {1'b1, who_ff};
            ptr_in  = ptr_ff + PW'(1);
            left_in = left_ff - CW'(1);
            prod_in = 32'(start_ff) * PAGE_BYTES_W;
            if (left_ff == CW'(1)) begin
               if (cmd_ff == pota_pkg::CMD_RESIZE && have_old_ff) begin
                  ptr_in   = PW'(mark_ff);
                  end_in   = (rel_sum > PAGES_S) ? PAGES_P : PW'(rel_sum);
                  pend_in  = 1'b0;
                  state_in = ST_REL_SCAN;
               end else begin
                  state_in = ST_DONE;
               end
            end
         end
         ST_REL_SCAN: begin
            if (pend_ff) begin
               wr_en = 1'b1;
               if (entry_busy) begin
                  freed_in = freed_ff + CW'(1);
               end
            end
            if (!issue && !pend_ff) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {1'b0, freed_ff,
                               claimed ? addr_out : 32'd0,
                               claimed ? pota_pkg::INDEX_W'(start_ff) : 6'd0,
                               status_ff};
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         ptr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         base_ff      <= pota_pkg::BASE_ADDRESS_RESET;
         pend_ff      <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ptr_ff       <= ptr_in;
         rsp_valid_ff <= rsp_valid_in;
         base_ff      <= base_in;
         pend_ff      <= pend_in;
      end
      end_ff      <= end_in;
      pend_idx_ff <= pend_idx_in;
      cmd_ff      <= cmd_in;
      who_ff      <= who_in;
      len_ff      <= len_in;
      old_ff      <= old_in;
      run_ff      <= run_in;
      found_ff    <= found_in;
      start_ff    <= start_in;
      have_old_ff <= have_old_in;
      mark_ff     <= mark_in;
      freed_ff    <= freed_in;
      left_ff     <= left_in;
      prod_ff     <= prod_in;
      status_ff   <= status_in;
      rsp_data_ff <= rsp_data_in;
   end

endmodule
